/* hw/rtl/lzss_stream_decoder_assert.svh */
// ----------------------------------------------------------------------------
// lzss stream decoder assertion macros
// Shared property forms for the decoder's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LZSS_STREAM_DECODER_ASSERT_SVH
`define LZSS_STREAM_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LZSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LZSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lzsd_pkg.sv */
// ----------------------------------------------------------------------------
// lzsd_pkg
// Types and constants shared by the lzss stream decoder modules.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  // output limit register
  localparam int unsigned LIMIT_W = 20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'h44000;

  // window contents before anything is written
  localparam logic [7:0] FILL_BYTE = 8'h20;

  // start position sits this far below the window end
  localparam int unsigned START_GAP = 18;

  // flag byte is loaded with a marker in the upper half
  localparam logic [15:0] FLAG_MARK = 16'hFF00;

  // shortest back reference
  localparam logic [4:0] MATCH_MIN = 5'd3;

  // command queue
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW = 2;

  // command kinds passed from parser to executor
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_COPY  = 2'd2
  } cmd_kind_e;

  // lo: literal byte or offset low byte, hi: second reference byte
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] lo;
    logic [7:0] hi;
  } cmd_t;

endpackage

/* hw/rtl/lzsd_ram.sv */
// ----------------------------------------------------------------------------
// lzsd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lzsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/lzsd_front.sv */
// ----------------------------------------------------------------------------
// lzsd_front
// Parses the compressed byte stream into stream start, literal and copy
// commands for the executor.
// ----------------------------------------------------------------------------
module lzsd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    data_byte_i,
  input  logic          first_of_stream_i,
  input  logic          full_i,
  output logic          push_o,
  output lzsd_pkg::cmd_t cmd_o
);

  localparam logic [1:0] PH_FLAG   = 2'd0;
  localparam logic [1:0] PH_ITEM   = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] flag_q, flag_d;
  logic [7:0]  lo_q, lo_d;
  logic        accept;
  logic [1:0]  cur_phase;
  logic [15:0] cur_flag;
  logic [15:0] next_flag;

  // stall only when the queue has no room
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // a stream start forces the byte to be read as a flag byte
  assign cur_phase = first_of_stream_i ? PH_FLAG : phase_q;
  assign cur_flag  = first_of_stream_i ? 16'h0000 : flag_q;
  assign next_flag = {1'b0, cur_flag[15:1]};

  // parser
  always_comb begin
    phase_d = phase_q;
    flag_d  = flag_q;
    lo_d    = lo_q;
    push_o  = 1'b0;
    cmd_o   = '{kind: lzsd_pkg::CMD_START, lo: data_byte_i, hi: data_byte_i};
    if (accept) begin
      if (first_of_stream_i) begin
        push_o = 1'b1;
        lo_d   = 8'h00;
      end
      unique case (cur_phase)
        PH_ITEM: begin
          if (cur_flag[0]) begin
            push_o     = 1'b1;
            cmd_o.kind = lzsd_pkg::CMD_LIT;
            flag_d     = next_flag;
            phase_d    = (next_flag[15:8] == 8'h00) ? PH_FLAG : PH_ITEM;
          end else begin
            lo_d    = data_byte_i;
            phase_d = PH_SECOND;
          end
        end
        PH_SECOND: begin
          push_o     = 1'b1;
          cmd_o.kind = lzsd_pkg::CMD_COPY;
          cmd_o.lo   = lo_q;
          flag_d     = next_flag;
          phase_d    = (next_flag[15:8] == 8'h00) ? PH_FLAG : PH_ITEM;
        end
        default: begin
          flag_d  = lzsd_pkg::FLAG_MARK | {8'h00, data_byte_i};
          phase_d = PH_ITEM;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG;
      flag_q  <= 16'h0000;
      lo_q    <= 8'h00;
    end else begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      lo_q    <= lo_d;
    end
  end

endmodule

/* hw/rtl/lzsd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// lzsd_cmd_fifo
// Small command queue between parser and executor.
// ----------------------------------------------------------------------------
module lzsd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzsd_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output lzsd_pkg::cmd_t cmd_o
);

  lzsd_pkg::cmd_t                 slot_q [lzsd_pkg::CMDQ_DEPTH];
  logic [lzsd_pkg::CMDQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lzsd_pkg::CMDQ_AW:0]     count_q;
  logic                           do_push, do_pop;

  assign full_o  = (count_q == (lzsd_pkg::CMDQ_AW + 1)'(lzsd_pkg::CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/lzsd_back.sv */
// ----------------------------------------------------------------------------
// lzsd_back
// Executes commands on the history window, one byte per unstalled cycle,
// via a read stage and a write/emit stage, bypassing the byte just written.
// ----------------------------------------------------------------------------
module lzsd_back #(
  parameter int unsigned WINDOW_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  lzsd_pkg::cmd_t               cmd_i,
  output logic                         pop_o,
  input  logic [lzsd_pkg::LIMIT_W-1:0] limit_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         last_of_run_o
);

  `include "lzss_stream_decoder_assert.svh"

  localparam int unsigned WinSize = 1 << WINDOW_BITS;
  localparam logic [WINDOW_BITS-1:0] StartPos =
    WINDOW_BITS'(WinSize - lzsd_pkg::START_GAP);
  localparam logic [WINDOW_BITS:0] FillFull = (WINDOW_BITS + 1)'(WinSize);

  // window position, fill level and stream byte count
  logic [WINDOW_BITS-1:0]       wp_q, wp_d;
  logic [WINDOW_BITS:0]         fill_q, fill_d;
  logic [lzsd_pkg::LIMIT_W-1:0] cnt_q, cnt_d;
  logic [4:0]                   idx_q, idx_d;

  // write/emit stage
  logic       s2_vld_q, s2_vld_d;
  logic       s2_held_q, s2_held_d;
  logic [7:0] s2_byte_q, s2_byte_d;
  logic       s2_ok_q, s2_ok_d;
  logic       s2_last_q, s2_last_d;

  // output register
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  logic                   adv, fire2, s1_free, emit, start_go;
  logic [7:0]             d2, ram_rdata;
  logic                   ren;
  logic [WINDOW_BITS-1:0] raddr, rel;
  logic [WINDOW_BITS-1:0] src;
  logic [4:0]             last_idx;

  // stage 2 advances when the output register can take a beat
  assign adv     = !out_vld_q || !out_stall_i;
  assign fire2   = s2_vld_q && adv;
  assign s1_free = !s2_vld_q || adv;

  // byte in stage 2: literal, bypassed, stored or never written
  assign d2 = s2_held_q ? s2_byte_q : (s2_ok_q ? ram_rdata : lzsd_pkg::FILL_BYTE);
  assign emit = fire2 && (cnt_q < limit_i);

  // copy source address and last index of the run
  assign src      = WINDOW_BITS'({cmd_i.hi[7:4], cmd_i.lo});
  assign last_idx = 5'(cmd_i.hi[3:0]) + lzsd_pkg::MATCH_MIN - 5'd1;
  assign raddr    = src + WINDOW_BITS'(idx_q);
  assign rel      = raddr - StartPos;

  // issue stage
  always_comb begin
    pop_o     = 1'b0;
    ren       = 1'b0;
    start_go  = 1'b0;
    idx_d     = idx_q;
    s2_held_d = s2_held_q;
    s2_byte_d = s2_byte_q;
    s2_ok_d   = s2_ok_q;
    s2_last_d = s2_last_q;
    s2_vld_d  = fire2 ? 1'b0 : s2_vld_q;
    if (cmd_valid_i && s1_free) begin
      unique case (cmd_i.kind)
        lzsd_pkg::CMD_START: begin
          if (!s2_vld_q) begin
            pop_o    = 1'b1;
            start_go = 1'b1;
          end
        end
        lzsd_pkg::CMD_LIT: begin
          pop_o     = 1'b1;
          s2_vld_d  = 1'b1;
          s2_held_d = 1'b1;
          s2_byte_d = cmd_i.lo;
          s2_ok_d   = 1'b1;
          s2_last_d = 1'b1;
        end
        lzsd_pkg::CMD_COPY: begin
          ren       = 1'b1;
          s2_vld_d  = 1'b1;
          s2_held_d = fire2 && (raddr == wp_q);
          s2_byte_d = d2;
          s2_ok_d   = ({1'b0, rel} < fill_q);
          s2_last_d = (idx_q == last_idx);
          if (idx_q == last_idx) begin
            pop_o = 1'b1;
            idx_d = 5'd0;
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  // write/emit stage and stream counters
  always_comb begin
    wp_d       = wp_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (start_go) begin
      wp_d   = StartPos;
      fill_d = '0;
      cnt_d  = '0;
    end else if (fire2) begin
      wp_d = wp_q + 1'b1;
      if (fill_q != FillFull) begin
        fill_d = fill_q + 1'b1;
      end
      if (emit) begin
        cnt_d      = cnt_q + 1'b1;
        out_vld_d  = 1'b1;
        out_byte_d = d2;
        out_last_d = s2_last_q || ((cnt_q + 1'b1) == limit_i);
      end
    end
  end

  // history window
  lzsd_ram #(
    .WIDTH (8),
    .DEPTH (WinSize)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (fire2),
    .waddr_i (wp_q),
    .wdata_i (d2),
    .re_i    (ren),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= StartPos;
      fill_q    <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s2_held_q  <= s2_held_d;
    s2_byte_q  <= s2_byte_d;
    s2_ok_q    <= s2_ok_d;
    s2_last_q  <= s2_last_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

  // checks
  `LZSD_ASSERT_NOW(a_emit_under_limit, clk_i, rst_ni, emit, cnt_q < limit_i, "emit at limit")
  `LZSD_ASSERT_NOW(a_start_drained, clk_i, rst_ni, start_go, !s2_vld_q, "start with byte in flight")
  `LZSD_ASSERT_NEXT(a_stall_holds_byte, clk_i, rst_ni, s2_vld_q && !adv, s2_vld_q && $stable(d2), "byte lost in stall")
  `LZSD_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FillFull, "fill level overrun")

endmodule

/* hw/rtl/lzss_stream_decoder.sv */
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decoder with a 4096-byte history window, fed one compressed byte per
// beat and producing one decompressed byte per beat.
// ----------------------------------------------------------------------------
// Each input beat is parsed at once and turned into at most one command in a
// four-entry queue, so the input side keeps running while bytes are still
// being produced. The executor behind the queue moves one byte per clock,
// unless the output stalls, through the single window RAM read port: a
// literal moves one byte, a back reference its length (3 to 18 bytes); flag
// bytes and pending first reference bytes cost nothing there; a stream start
// takes a slot once the byte in flight is written. Sustained input rate is
// thus set by the window port. The window needs no clearing pass: a fill
// count since stream start marks which entries have been written, others
// read as space. The user must write output_limit through the config channel
// while the block is idle, not enforced by the block; it applies per stream.
// ----------------------------------------------------------------------------
module lzss_stream_decoder #(
  parameter int unsigned WINDOW_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // compressed input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_stream_i,
  // decompressed output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  // output limit register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i
);

  logic [lzsd_pkg::LIMIT_W-1:0] limit_q;
  logic                         push, full, cmd_valid, pop;
  lzsd_pkg::cmd_t               push_cmd, head_cmd;

  // limit register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lzsd_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // parser
  lzsd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .first_of_stream_i (first_of_stream_i),
    .full_i            (full),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  // command queue
  lzsd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  // executor
  lzsd_back #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .limit_i       (limit_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lzss stream decoder. Compressed bytes go in
// through the stall handshake, and a software decoder with its own window
// predicts every decompressed byte and run marker. Results are checked in
// order as they leave the block. The output limit is rewritten between
// phases, and the idle pattern changes with each pair of phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned PHASE_BEATS  = 4;
  localparam int unsigned NUM_PHASES   = 6;

  // parse position of the software decoder
  typedef enum logic [1:0] {
    WANT_FLAG   = 2'd0,
    WANT_ITEM   = 2'd1,
    WANT_SECOND = 2'd2
  } parse_state_e;

  // one decompressed byte as the block should emit it
  typedef struct {
    logic [7:0] data;
    logic       last;
  } plain_byte_t;

  // software decoder plus the queue of bytes it still waits for
  class lzss_byte_tracker;
    logic [7:0]                   window [4096];
    logic [11:0]                  wpos;
    logic [15:0]                  flags;
    parse_state_e                 state;
    logic [7:0]                   offset_lo;
    logic [lzsd_pkg::LIMIT_W-1:0] out_count;
    logic [lzsd_pkg::LIMIT_W-1:0] limit;
    plain_byte_t                  awaited [$];
    int                           errors;

    function new();
      limit  = lzsd_pkg::LIMIT_RESET;
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (window[i]) window[i] = lzsd_pkg::FILL_BYTE;
      wpos      = 12'(4096 - lzsd_pkg::START_GAP);
      flags     = '0;
      state     = WANT_FLAG;
      offset_lo = '0;
      out_count = '0;
    endfunction

    // window write, plus an output byte while under the limit
    function void emit(logic [7:0] v, ref plain_byte_t run [$]);
      plain_byte_t pb;
      window[wpos] = v;
      wpos = wpos + 12'd1;
      if (out_count < limit) begin
        out_count = out_count + 1'b1;
        pb.data = v;
        pb.last = 1'b0;
        run.push_back(pb);
      end
    endfunction

    function void advance();
      flags = flags >> 1;
      state = (flags[15:8] == 8'd0) ? WANT_FLAG : WANT_ITEM;
    endfunction

    // called for every accepted compressed beat
    function void take_code_byte(logic [7:0] b, logic first);
      plain_byte_t run [$];
      logic [11:0] src;
      int unsigned len;
      if (first) restart();
      case (state)
        WANT_ITEM: begin
          if (flags[0]) begin
            emit(b, run);
            advance();
          end else begin
            offset_lo = b;
            state = WANT_SECOND;
          end
        end
        WANT_SECOND: begin
          src = {b[7:4], offset_lo};
          len = int'(b[3:0]) + int'(lzsd_pkg::MATCH_MIN);
          for (int i = 0; i < len; i++) emit(window[src + 12'(i)], run);
          advance();
        end
        default: begin
          flags = lzsd_pkg::FLAG_MARK | {8'd0, b};
          state = WANT_ITEM;
        end
      endcase
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) awaited.push_back(run[i]);
    endfunction

    // called for every accepted output beat
    function void match_out_byte(logic [7:0] b, logic last);
      plain_byte_t exp_b;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected out beat: expected none, actual byte %02h last %0b",
                 $time, b, last);
        return;
      end
      exp_b = awaited.pop_front();
      if (b !== exp_b.data) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                 $time, exp_b.data, b);
      end
      if (last !== exp_b.last) begin
        errors++;
        $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                 $time, exp_b.last, last);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i       = 8'd0;
  logic        first_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [19:0] cfg_data_i        = 20'd0;

  lzss_byte_tracker tracker = new();
  int unsigned      cycle_count   = 0;
  int unsigned      beats_sent    = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;

  lzss_stream_decoder #(
    .WINDOW_BITS(12)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .first_of_stream_i(first_of_stream_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // output beat check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_out_byte(out_byte_o, last_of_run_o);
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one compressed beat, with random gaps before it
  task automatic send_byte(logic [7:0] b, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    data_byte_i       <= b;
    first_of_stream_i <= first;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_code_byte(b, first);
    beats_sent++;
  endtask

  // flag byte and its items; sometimes cut short to leave a stream truncated
  task automatic send_group(logic start_new, output logic cut);
    logic [7:0]  flag_b;
    logic [11:0] src;
    int unsigned stop_at;
    flag_b  = 8'($urandom_range(255));
    stop_at = ($urandom_range(9) == 0) ? $urandom_range(7) : 8;
    send_byte(flag_b, start_new);
    for (int i = 0; i < stop_at; i++) begin
      if (flag_b[i]) begin
        send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        // half the time recent history, so copies overlap what was just written
        case ($urandom_range(3))
          0, 1:    src = tracker.wpos - 12'($urandom_range(20, 1));
          2:       src = 12'($urandom_range(4095));
          default: src = tracker.wpos + 12'($urandom_range(40));
        endcase
        send_byte(src[7:0], 1'b0);
        send_byte({src[11:8], 4'($urandom_range(15))}, 1'b0);
      end
    end
    cut = (stop_at < 8);
    // leave a reference half sent
    if (cut && !flag_b[stop_at] && $urandom_range(1) == 1)
      send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // wait until every predicted byte is out and the executor has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [19:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.limit = v;
  endtask

  // stimulus
  initial begin
    logic [19:0] limits [NUM_PHASES];
    int unsigned phase_start;
    int unsigned groups;
    logic        new_stream;
    logic        fresh_phase;
    logic        cut;

    limits = '{20'hFFFFF, 20'd0, 20'd9, 20'd1, 20'd45, 20'hFFFFF};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first stream continues from reset state, reset limit
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    // overlapping copy of length 18 starting at the first written byte
    send_byte(8'hEE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // shortest copy from window start, overlapping the write position
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // copy from the window end, wrapping around
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h7F, 1'b0);
    // new stream, then restart while items are still pending
    send_byte(8'hFF, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    // restart with a reference half sent; copy reads only spaces
    send_byte(8'h00, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h5A, 1'b0);

    // random phases, each with its own limit; idle pattern set per pair of phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_limit(limits[p]);
      case (p / 2)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = beats_sent;
      fresh_phase = 1'b1;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(9) < 8) begin
          groups     = $urandom_range(2, 1);
          new_stream = fresh_phase || ($urandom_range(3) != 0);
          for (int g = 0; g < groups; g++) begin
            send_group((g == 0) && new_stream, cut);
            if (cut) break;
          end
        end else begin
          // noise beats
          repeat ($urandom_range(4, 1))
            send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
        end
        fresh_phase = 1'b0;
      end
    end

    drain();
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
